[hw/rtl/dabf0_pkg.sv]
// ----------------------------------------------------------------------------
// FIG 0 record parser package
// Shared types and constants for the FIG type 0 record parser.
// ----------------------------------------------------------------------------
package dabf0_pkg;

  localparam int unsigned ServiceSlots = 32;
  localparam int unsigned SlotIdxW     = (ServiceSlots > 1) ? $clog2(ServiceSlots) : 1;
  localparam int unsigned SlotCntW     = $clog2(ServiceSlots + 1);
  localparam int unsigned SrefW        = 20;

  localparam logic [4:0] ExtSubch   = 5'd1;
  localparam logic [4:0] ExtService = 5'd2;
  localparam logic [4:0] ExtTime    = 5'd10;

  typedef enum logic [1:0] {
    KIND_SUBCH   = 2'd0,
    KIND_SERVICE = 2'd1,
    KIND_COMP    = 2'd2,
    KIND_TIME    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_fig;
    logic       last_of_fig;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [31:0] ident;
    logic        long_form;
    logic [2:0]  mode_code;
    logic [5:0]  level_or_type;
    logic [9:0]  start_or_ecc;
    logic [9:0]  size_or_index;
    logic        flag_primary;
    logic        flag_ca;
  } out_item_t;

  // job handed from front to back: a plain result or a service candidate
  typedef struct packed {
    logic             is_service;   // 0: plain result, 1: needs table lookup
    logic [SrefW-1:0] sref;
    logic [3:0]       comp_count;
    out_item_t        res;
  } job_t;

endpackage

[hw/rtl/dab_fig0_record_parser.sv]
// ----------------------------------------------------------------------------
// FIG 0 record parser
// Decodes sub-channel, service/component and UTC time records of FIG type 0.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive one FIG byte with its first/last marks and push;
//   the item is taken when full is low. Results appear as a queue: while
//   empty is low the oldest record sits on record_o; pop takes it.
//   A completed record is written to the job queue and moves on to the
//   output register once that register is free.
//   A service record runs a search of the reference table, one stored entry
//   per cycle through the table RAM read port, over every stored service
//   (at most ServiceSlots). The input stays full during that search, since
//   the outcome decides whether the following components are dropped.
//   Other bytes go at one per cycle while the job queue has room.
//   When the receiver stalls, results pile into the two-entry job queue and
//   the output register; full then rises and holds the input.
//   Reset clears the sub-channel map, the table fill count and all control
//   state; the table RAM needs no clearing since only filled slots are read.
// ----------------------------------------------------------------------------
module dab_fig0_record_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  dabf0_pkg::in_item_t  item_i,
  output logic                 full,
  output logic                 empty,
  input  logic                 pop,
  output dabf0_pkg::out_item_t record_o
);
  import dabf0_pkg::*;

  logic jv, qready, qvalid, qtake, done, dup;
  job_t jin, jout;

  dabf0_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_i        (item_i),
    .full_o      (full),
    .job_valid_o (jv),
    .job_o       (jin),
    .job_ready_i (qready),
    .svc_done_i  (done),
    .svc_dup_i   (dup)
  );

  dabf0_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (jv),
    .wdata_i (jin),
    .ready_o (qready),
    .valid_o (qvalid),
    .rdata_o (jout),
    .rd_i    (qtake)
  );

  dabf0_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (qvalid),
    .job_i       (jout),
    .job_take_o  (qtake),
    .svc_done_o  (done),
    .svc_dup_o   (dup),
    .empty_o     (empty),
    .res_o       (record_o),
    .pop_i       (pop)
  );

`ifndef ASSERT_OFF
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qtake |-> qvalid) else $error("job taken from empty queue");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jv |-> qready) else $error("job queue overflow");
  a_done_service: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (qtake && jout.is_service)) else $error("lookup done without service");
`endif
endmodule

[hw/rtl/dabf0_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module dabf0_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hw/rtl/dabf0_front.sv]
// ----------------------------------------------------------------------------
// FIG 0 front end
// Assembles record bytes, decodes fields and issues jobs to the back end.
// The front end waits while a service lookup is pending, since the dedup
// outcome decides whether the following component entries are skipped.
// ----------------------------------------------------------------------------
module dabf0_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dabf0_pkg::in_item_t in_i,
  output logic                full_o,
  output logic                job_valid_o,
  output dabf0_pkg::job_t     job_o,
  input  logic                job_ready_i,
  input  logic                svc_done_i,
  input  logic                svc_dup_i
);
  import dabf0_pkg::*;

  logic [4:0]  ext_q, ext_d;
  logic        lid_q, lid_d;
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  rb_q [6];
  logic        inc_q, inc_d;
  logic [3:0]  left_q, left_d;
  logic        skip_q, skip_d;
  logic [63:0] seen_q, seen_d;
  logic        wait_q, wait_d;
  logic        jv;
  job_t        job;

  logic [7:0] b;
  logic [7:0] r0, r1, r2, r3, r4, r5;
  logic [5:0] sid_id;
  logic [19:0] sref;
  logic [7:0] info;
  logic       fire;

  assign b      = in_i.data_byte;
  assign fire   = push_i && !full_o;
  assign full_o = wait_q || !job_ready_i;

  // current record view with the incoming byte merged at pos_q
  always_comb begin
    r0 = (pos_q == 3'd0) ? b : rb_q[0];
    r1 = (pos_q == 3'd1) ? b : rb_q[1];
    r2 = (pos_q == 3'd2) ? b : rb_q[2];
    r3 = (pos_q == 3'd3) ? b : rb_q[3];
    r4 = (pos_q == 3'd4) ? b : rb_q[4];
    r5 = (pos_q == 3'd5) ? b : rb_q[5];
  end

  assign sid_id = r0[7:2];

  always_comb begin
    ext_d  = ext_q;
    lid_d  = lid_q;
    pos_d  = pos_q;
    inc_d  = inc_q;
    left_d = left_q;
    skip_d = skip_q;
    seen_d = seen_q;
    wait_d = wait_q;
    jv     = 1'b0;
    job    = '0;
    sref   = '0;
    info   = '0;
    if (wait_q && svc_done_i) begin
      wait_d = 1'b0;
      skip_d = svc_dup_i && inc_q;
    end
    if (fire) begin
      if (in_i.first_of_fig) begin
        ext_d  = b[4:0];
        lid_d  = b[5];
        pos_d  = '0;
        inc_d  = 1'b0;
        left_d = '0;
        skip_d = 1'b0;
      end else if (ext_q == ExtSubch) begin
        pos_d = pos_q + 3'd1;
        if ((pos_q == 3'd2 && !r2[7]) || pos_q == 3'd3) begin
          pos_d = '0;
          if (!seen_q[sid_id]) begin
            seen_d[sid_id]         = 1'b1;
            jv                     = 1'b1;
            job.res.record_kind    = KIND_SUBCH;
            job.res.ident          = {26'd0, sid_id};
            job.res.start_or_ecc   = {r0[1:0], r1};
            if (r2[7]) begin
              job.res.long_form     = 1'b1;
              job.res.mode_code     = r2[6:4];
              job.res.level_or_type = {4'd0, r2[3:2]};
              job.res.size_or_index = {r2[1:0], r3};
            end else begin
              job.res.size_or_index = {4'd0, r2[5:0]};
              job.res.flag_primary  = r2[6];
            end
          end
        end
      end else if (ext_q == ExtService) begin
        pos_d = pos_q + 3'd1;
        if (inc_q) begin
          if (pos_q == 3'd1) begin
            pos_d  = '0;
            left_d = left_q - 4'd1;
            if (left_d == 4'd0) begin
              inc_d  = 1'b0;
              skip_d = 1'b0;
            end
            if (!skip_q) begin
              jv                   = 1'b1;
              job.res.record_kind  = KIND_COMP;
              job.res.mode_code    = {1'b0, r0[7:6]};
              job.res.flag_primary = r1[1];
              job.res.flag_ca      = r1[0];
              if (r0[7:6] == 2'd3) begin
                job.res.ident = {20'd0, r0[5:0], r1[7:2]};
              end else begin
                job.res.ident         = {26'd0, r1[7:2]};
                job.res.level_or_type = r0[5:0];
              end
            end
          end
        end else if ((lid_q && pos_q == 3'd4) || (!lid_q && pos_q == 3'd2)) begin
          pos_d = '0;
          jv    = 1'b1;
          job.is_service = 1'b1;
          if (lid_q) begin
            info                 = r4;
            sref                 = {r1[3:0], r2, r3};
            job.res.ident        = {r0, r1, r2, r3};
            job.res.start_or_ecc = {2'd0, r0};
            job.res.level_or_type = {2'd0, r1[7:4]};
          end else begin
            info                 = r2;
            sref                 = {8'd0, r0[3:0], r1};
            job.res.ident        = {16'd0, r0, r1};
            job.res.level_or_type = {2'd0, r0[7:4]};
          end
          job.sref              = sref;
          job.comp_count        = info[3:0];
          job.res.record_kind   = KIND_SERVICE;
          job.res.long_form     = lid_q;
          job.res.mode_code     = info[6:4];
          job.res.size_or_index = {6'd0, info[3:0]};
          job.res.flag_primary  = info[7];
          left_d = info[3:0];
          inc_d  = info[3:0] != 4'd0;
          skip_d = 1'b0;
          wait_d = 1'b1;
        end
      end else if (ext_q == ExtTime) begin
        if (pos_q < 3'd6) begin
          pos_d = pos_q + 3'd1;
          if ((pos_q == 3'd3 && !r2[3]) || pos_q == 3'd5) begin
            pos_d = 3'd7;
            jv    = 1'b1;
            job.res.record_kind   = KIND_TIME;
            job.res.ident         = {27'd0, r2[2:0], r3[7:6]};
            job.res.long_form     = r2[3];
            job.res.level_or_type = r3[5:0];
            if (r2[3]) begin
              job.res.start_or_ecc  = {r4[1:0], r5};
              job.res.size_or_index = {4'd0, r4[7:2]};
            end
          end
        end
      end
      if (in_i.last_of_fig) begin
        pos_d  = '0;
        inc_d  = 1'b0;
        left_d = '0;
        skip_d = 1'b0;
        ext_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q  <= '0;
      lid_q  <= 1'b0;
      pos_q  <= '0;
      inc_q  <= 1'b0;
      left_q <= '0;
      skip_q <= 1'b0;
      seen_q <= '0;
      wait_q <= 1'b0;
    end else begin
      ext_q  <= ext_d;
      lid_q  <= lid_d;
      pos_q  <= pos_d;
      inc_q  <= inc_d;
      left_q <= left_d;
      skip_q <= skip_d;
      seen_q <= seen_d;
      wait_q <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && !in_i.first_of_fig && pos_q < 3'd6) begin
      rb_q[pos_q] <= b;
    end
  end

  assign job_valid_o = jv;
  assign job_o       = job;
endmodule

[hw/rtl/dabf0_fifo.sv]
// ----------------------------------------------------------------------------
// FIG 0 job queue
// Two-entry queue between front and back end.
// ----------------------------------------------------------------------------
module dabf0_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  dabf0_pkg::job_t wdata_i,
  output logic            ready_o,
  output logic            valid_o,
  output dabf0_pkg::job_t rdata_o,
  input  logic            rd_i
);
  import dabf0_pkg::*;

  job_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign rdata_o = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr_i) begin
        wp_q <= ~wp_q;
      end
      if (rd_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wp_q] <= wdata_i;
    end
  end
endmodule

[hw/rtl/dabf0_back.sv]
// ----------------------------------------------------------------------------
// FIG 0 back end
// Runs the service reference search over the table RAM and drives the
// output register.
// ----------------------------------------------------------------------------
module dabf0_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  dabf0_pkg::job_t      job_i,
  output logic                 job_take_o,
  output logic                 svc_done_o,
  output logic                 svc_dup_o,
  output logic                 empty_o,
  output dabf0_pkg::out_item_t res_o,
  input  logic                 pop_i
);
  import dabf0_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StEnd  = 2'd2;

  logic [1:0]          st_q, st_d;
  logic [SlotCntW-1:0] cnt_q, cnt_d;
  logic [SlotCntW-1:0] idx_q, idx_d;
  logic                dup_q, dup_d;
  logic                rvld_q, rvld_d;
  logic                ov_q, ov_d;
  out_item_t           res_q, res_d;
  logic                we;
  logic [SrefW-1:0]    rdata;
  logic [SlotIdxW-1:0] raddr;
  logic                ok_out;

  // read slot 0 while idle so the scan starts at the first entry
  assign raddr = (st_q == StIdle) ? '0 : idx_q[SlotIdxW-1:0];

  dabf0_ram #(.Width(SrefW), .Depth(ServiceSlots)) u_tab (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[SlotIdxW-1:0]),
    .wdata_i (job_i.sref),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ok_out  = !ov_q || pop_i;
  assign empty_o = !ov_q;
  assign res_o   = res_q;

  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    dup_d      = dup_q;
    rvld_d     = 1'b0;
    ov_d       = ov_q && !pop_i;
    res_d      = res_q;
    job_take_o = 1'b0;
    svc_done_o = 1'b0;
    svc_dup_o  = 1'b0;
    we         = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (job_valid_i) begin
          if (!job_i.is_service) begin
            if (ok_out) begin
              job_take_o = 1'b1;
              ov_d       = 1'b1;
              res_d      = job_i.res;
            end
          end else begin
            dup_d = 1'b0;
            idx_d = '0;
            st_d  = StScan;
            // issue first read when table holds anything
            rvld_d = cnt_q != '0;
            if (cnt_q != '0) begin
              idx_d = {{(SlotCntW-1){1'b0}}, 1'b1};
            end else begin
              st_d = StEnd;
            end
          end
        end
      end
      StScan: begin
        // one stored reference compared per cycle
        if (rvld_q && rdata == job_i.sref) begin
          dup_d = 1'b1;
        end
        if (idx_q < cnt_q) begin
          rvld_d = 1'b1;
          idx_d  = idx_q + 1'b1;
        end else begin
          st_d = StEnd;
        end
      end
      StEnd: begin
        if (dup_q) begin
          job_take_o = 1'b1;
          svc_done_o = 1'b1;
          svc_dup_o  = 1'b1;
          st_d       = StIdle;
        end else if (ok_out) begin
          job_take_o = 1'b1;
          svc_done_o = 1'b1;
          ov_d       = 1'b1;
          res_d      = job_i.res;
          st_d       = StIdle;
          if (cnt_q < SlotCntW'(ServiceSlots)) begin
            we    = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      cnt_q  <= '0;
      idx_q  <= '0;
      dup_q  <= 1'b0;
      rvld_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      dup_q  <= dup_d;
      rvld_q <= rvld_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end
endmodule
